/* src/rrip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_pkg: shared types and constants
// Command codes, sequencer states and field widths of the replacement engine.
// ----------------------------------------------------------------------------
package rrip_pkg;

  localparam int unsigned AddrW   = 20;
  localparam int unsigned DeltaW  = 21;
  localparam int unsigned StreakW = 3;
  localparam int unsigned PcW     = 13;
  localparam int unsigned RrpvW   = 2;
  localparam logic [RrpvW-1:0] RrpvMax = 2'd3;
  localparam logic [StreakW-1:0] StreakMax = 3'd7;
  localparam logic [2:0] StreamLenReset = 3'd3;
  localparam int unsigned LeaderCount = 32;

  typedef enum logic {
    CMD_VICTIM = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPD,
    ST_CTR
  } state_e;

endpackage

/* src/rrip_stride.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_stride: per-set stride detector
// Stores last address, last delta and streak per set in one memory row.
// Read is registered; evaluate and write back in the cycle after the read.
// ----------------------------------------------------------------------------
module rrip_stride
  import rrip_pkg::*;
#(
  parameter int unsigned SetW = 11
) (
  input  logic            clk_i,
  input  logic            rd_i,
  input  logic [SetW-1:0] rd_set_i,
  input  logic            wr_i,
  input  logic [SetW-1:0] wr_set_i,
  input  logic            clr_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [2:0]      stream_len_i,
  output logic            streaming_o
);

  localparam int unsigned RowW = AddrW + DeltaW + StreakW;

  logic [RowW-1:0] mem_q [2**SetW];
  logic [RowW-1:0] row_q;
  logic [AddrW-1:0]   last_addr;
  logic [DeltaW-1:0]  prev_delta, delta;
  logic [StreakW-1:0] streak, streak_new;
  logic               same;
  logic [RowW-1:0]    row_new;

  assign {last_addr, prev_delta, streak} = row_q;
  assign delta = {1'b0, addr_i} - {1'b0, last_addr};
  assign same  = (streak != '0) && (delta == prev_delta) && (delta != '0);

  always_comb begin
    streak_new  = 3'd1;
    streaming_o = 1'b0;
    row_new     = {addr_i, delta, 3'd1};
    if (same) begin
      streak_new  = (streak < StreakMax) ? streak + 3'd1 : streak;
      streaming_o = (streak_new >= stream_len_i);
      row_new     = {addr_i, prev_delta, streak_new};
    end
    if (clr_i) begin
      row_new = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_set_i] <= row_new;
    end
    if (rd_i) begin
      row_q <= mem_q[rd_set_i];
    end
  end

endmodule

/* src/rrip_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_row: set metadata memory
// One row per set holding the RRPV and signature of every way.
// ----------------------------------------------------------------------------
module rrip_row #(
  parameter int unsigned SetW = 11,
  parameter int unsigned RowW = 128
) (
  input  logic            clk_i,
  input  logic            rd_i,
  input  logic [SetW-1:0] rd_set_i,
  input  logic            wr_i,
  input  logic [SetW-1:0] wr_set_i,
  input  logic [RowW-1:0] wr_data_i,
  output logic [RowW-1:0] rd_data_o
);

  logic [RowW-1:0] mem_q [2**SetW];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_set_i] <= wr_data_i;
    end
    if (rd_i) begin
      rd_data_o <= mem_q[rd_set_i];
    end
  end

endmodule

/* src/rrip_ship_stream_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_ship_stream_replacement: DRRIP + signature replacement engine
// Victim selection and hit/fill update for a set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//   Issue an item by raising start while busy is low; the fields are
//   sampled on that edge. One result appears later with done_o high for a
//   single cycle; the receiver cannot stall it.
//   Victim request: load the row, then a shared compare unit ages the
//   row by one step per cycle until a way holds 3 (0..3 steps), then picks
//   the lowest such way.
//   Update: read row, stride entry and reuse counter, decide RRPV and write
//   the stride entry, write the row, then update the shared reuse counter
//   and, for leader sets, the selector.
//   No new item is taken until the previous one is done; busy is high throughout.
//   After reset a clearing pass walks max(NUM_SETS, 2^SIGNATURE_BITS)
//   entries, one per cycle, writing RRPV 3, signature 0, a zero stride entry
//   and a zero reuse counter; busy stays high meanwhile. The config
//   channel (cfg_valid_i/cfg_ready_o) takes stream_length at any time and
//   is always ready.
// ----------------------------------------------------------------------------
module rrip_ship_stream_replacement
  import rrip_pkg::*;
#(
  parameter int unsigned NUM_SETS       = 2048,
  parameter int unsigned NUM_WAYS       = 16,
  parameter int unsigned SELECTOR_BITS  = 10,
  parameter int unsigned SIGNATURE_BITS = 6,
  parameter int unsigned LEADER_SPACING = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  input  logic        cmd_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_i,
  input  logic        hit_i,
  input  logic [12:0] pc_i,
  input  logic [19:0] addr_i,
  output logic [3:0]  victim_way_o,
  output logic [1:0]  new_rrpv_o,
  output logic        streaming_seen_o
);

  localparam int unsigned SetW  = $clog2(NUM_SETS);
  localparam int unsigned WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned SigW  = SIGNATURE_BITS;
  localparam int unsigned EntW  = RrpvW + SigW;
  localparam int unsigned RowW  = NUM_WAYS * EntW;
  localparam int unsigned SelW  = SELECTOR_BITS;
  localparam int unsigned LsW   = $clog2(LEADER_SPACING);
  localparam int unsigned ClrN  = (NUM_SETS > 2**SigW) ? NUM_SETS : 2**SigW;
  localparam int unsigned ClrW  = $clog2(ClrN);
  localparam logic [SelW-1:0] SelMax  = {SelW{1'b1}};
  localparam logic [SelW-1:0] SelInit = SelMax >> 1;
  localparam logic [LsW-1:0]  BrripOff = LsW'(LEADER_SPACING / 2);

  state_e state_q, state_d;
  logic [2:0]      stream_len_q;
  logic [SelW-1:0] sel_q, sel_d;
  logic [1:0]      ctr_mem [2**SigW];
  logic [1:0]      ctr_new_q, ctr_old_q;
  logic [ClrW-1:0] clr_q;

  logic            cmd_q, hit_q, strm_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] way_q;
  logic [SigW-1:0] sig_q, old_sig_q;
  logic [AddrW-1:0] addr_q;
  logic [RowW-1:0] row_q, row_d;
  logic [RrpvW-1:0] r_q;
  logic [3:0]      victim_q;
  logic            done_q;

  logic [RowW-1:0] row_rd, row_wdata;
  logic            row_rd_en, row_wr_en;
  logic [SetW-1:0] row_wset;
  logic            strm;
  logic            srrip_lead, brrip_lead, pick_srrip;
  logic [SetW-1:0] set_in;
  logic [SetW-1:0] lead_idx;
  logic            found;
  logic [WayW-1:0] first_way;
  logic [SigW-1:0] sig_in;
  logic            clr_active;
  logic [PcW-1:0]  pc_sh2, pc_sh7;

  assign set_in     = SetW'(set_index_i % NUM_SETS);
  assign pc_sh2     = pc_i >> 2;
  assign pc_sh7     = pc_i >> 7;
  assign sig_in     = SigW'(pc_sh2 ^ pc_sh7);
  assign clr_active = (state_q == ST_CLEAR);

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  assign row_rd_en = (state_q == ST_IDLE) && start;
  assign row_wr_en = clr_active || (state_q == ST_UPD) ||
                     ((state_q == ST_SCAN) && !found);
  assign row_wset  = clr_active ? SetW'(clr_q) : set_q;

  always_comb begin
    row_wdata = row_d;
    if (clr_active) begin
      for (int i = 0; i < NUM_WAYS; i++) begin
        row_wdata[i*EntW +: EntW] = {RrpvMax, {SigW{1'b0}}};
      end
    end
  end

  rrip_row #(.SetW(SetW), .RowW(RowW)) u_row (
    .clk_i,
    .rd_i      (row_rd_en),
    .rd_set_i  (set_in),
    .wr_i      (row_wr_en),
    .wr_set_i  (row_wset),
    .wr_data_i (row_wdata),
    .rd_data_o (row_rd)
  );

  rrip_stride #(.SetW(SetW)) u_stride (
    .clk_i,
    .rd_i         (row_rd_en),
    .rd_set_i     (set_in),
    .wr_i         (clr_active || ((state_q == ST_READ) && cmd_q)),
    .wr_set_i     (row_wset),
    .clr_i        (clr_active),
    .addr_i       (addr_q),
    .stream_len_i (stream_len_q),
    .streaming_o  (strm)
  );

  // --------------------------------------------------------------------------
  // Shared compare/age unit over the working row
  // --------------------------------------------------------------------------
  always_comb begin
    found     = 1'b0;
    first_way = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (row_q[i*EntW + SigW +: RrpvW] == RrpvMax) begin
        found     = 1'b1;
        first_way = WayW'(i);
      end
    end
  end

  assign lead_idx   = set_q >> LsW;
  assign srrip_lead = (LsW'(set_q) == '0) && (lead_idx < LeaderCount);
  assign brrip_lead = !srrip_lead && (LsW'(set_q) == BrripOff) &&
                      (lead_idx < LeaderCount);
  assign pick_srrip = srrip_lead || (!brrip_lead && (sel_q >= SelInit));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    sel_d   = sel_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ClrW'(ClrN - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_READ;
      end
      ST_READ: begin
        row_d   = row_rd;
        state_d = (cmd_q == CMD_UPDATE) ? ST_UPD : ST_SCAN;
      end
      ST_SCAN: begin
        // age by one step until some way reaches 3
        if (found) begin
          state_d = ST_IDLE;
        end else begin
          for (int i = 0; i < NUM_WAYS; i++) begin
            row_d[i*EntW + SigW +: RrpvW] = row_q[i*EntW + SigW +: RrpvW] + 2'd1;
          end
        end
      end
      ST_UPD: begin
        state_d = ST_CTR;
      end
      ST_CTR: begin
        state_d = ST_IDLE;
        if (srrip_lead) begin
          if (hit_q && sel_q < SelMax) sel_d = sel_q + 1'b1;
          else if (!hit_q && sel_q > '0) sel_d = sel_q - 1'b1;
        end else if (brrip_lead) begin
          if (hit_q && sel_q > '0) sel_d = sel_q - 1'b1;
          else if (!hit_q && sel_q < SelMax) sel_d = sel_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_UPD) begin
      row_d[way_q*EntW +: EntW] = {r_q, hit_q ? old_sig_q : sig_q};
    end
  end

  // rrpv decision made in READ, once stride and row data are out
  logic [RrpvW-1:0] r_new;
  logic [SigW-1:0]  line_sig;
  assign line_sig = row_rd[way_q*EntW +: SigW];
  always_comb begin
    if (hit_q) r_new = '0;
    else if (strm) r_new = RrpvMax;
    else if (ctr_new_q == 2'd3) r_new = '0;
    else r_new = pick_srrip ? 2'd1 : 2'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      stream_len_q <= StreamLenReset;
      sel_q        <= SelInit;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      if (clr_active) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) stream_len_q <= cfg_data_i;
      done_q <= ((state_q == ST_SCAN) && found) || (state_q == ST_CTR);
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    // reuse counters: one read on accept, one in READ, one write in CTR
    if (clr_active) begin
      ctr_mem[SigW'(clr_q)] <= '0;
    end else if (state_q == ST_CTR) begin
      if (hit_q) begin
        if (ctr_old_q < 2'd3) ctr_mem[old_sig_q] <= ctr_old_q + 2'd1;
      end else if (ctr_old_q > 2'd0) begin
        ctr_mem[old_sig_q] <= ctr_old_q - 2'd1;
      end
    end
    if (row_rd_en) begin
      cmd_q     <= cmd_i;
      hit_q     <= hit_i;
      set_q     <= set_in;
      way_q     <= WayW'(way_i % NUM_WAYS);
      sig_q     <= sig_in;
      addr_q    <= addr_i;
      ctr_new_q <= ctr_mem[sig_in];
    end
    if (state_q == ST_READ) begin
      old_sig_q <= line_sig;
      ctr_old_q <= ctr_mem[line_sig];
      r_q       <= r_new;
      strm_q    <= cmd_q && strm;
    end
    if (state_q == ST_SCAN) victim_q <= 4'(first_way);
  end

  assign done_o           = done_q;
  assign victim_way_o     = cmd_q ? 4'd0 : victim_q;
  assign new_rrpv_o       = cmd_q ? r_q : 2'd0;
  assign streaming_seen_o = cmd_q ? strm_q : 1'b0;

  ast_busy_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(start && !busy))
    else $error("result one cycle after accept");
  ast_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in a row");
  ast_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == ST_IDLE)
    else $error("result while busy");

endmodule
